/* hw/rtl/int_to_decimal_ascii_macros.svh */
// Assertion macros used by the checker file of the decimal text converter.
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// Overlapping implication, disabled while reset is high.
`define I2DA_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define I2DA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/i2da_pkg.sv */
// Shared widths and character codes of the decimal text converter.
`timescale 1ns / 1ps

package i2da_pkg;

  localparam int VALUE_BITS = 32;
  // Decimal digits needed for a magnitude up to 2^(VALUE_BITS-1).
  localparam int DIGITS   = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_BITS = DIGITS * 4;
  localparam int CNT_BITS = $clog2(VALUE_BITS);
  localparam int DIG_BITS = $clog2(DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_NINE  = 8'd57;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

endpackage

/* hw/rtl/i2da_dabble.sv */
// One shift-and-add-3 step of the binary to BCD conversion.
`timescale 1ns / 1ps

module i2da_dabble (
  input  logic [i2da_pkg::BCD_BITS-1:0]   bcd,
  input  logic [i2da_pkg::VALUE_BITS-1:0] mag,
  output logic [i2da_pkg::BCD_BITS-1:0]   bcd_next,
  output logic [i2da_pkg::VALUE_BITS-1:0] mag_next
);

  logic [i2da_pkg::BCD_BITS-1:0] adjusted;

  // Correct every nibble of 5 or more before the shift doubles it.
  always_comb begin
    for (int i = 0; i < i2da_pkg::DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        adjusted[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  assign bcd_next = {adjusted[i2da_pkg::BCD_BITS-2:0], mag[i2da_pkg::VALUE_BITS-1]};
  assign mag_next = {mag[i2da_pkg::VALUE_BITS-2:0], 1'b0};

endmodule

/* hw/rtl/int_to_decimal_ascii.sv */
// Signed integer to decimal ASCII text, one character per output request.
// Steps: load, VALUE_BITS (32) shift-add-3 steps, drop each leading zero, decide on
// the sign, then the characters, each waiting for a free output slot.
// A new value is taken only in idle, once the last character of the previous one has
// been issued; the single shared dabble step serves every shift, and output stalls hold it up.
// Reset (synchronous, active high) returns to idle and drops any pending output.
`timescale 1ns / 1ps

module int_to_decimal_ascii (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 value_valid,
  output logic                                 value_ready,
  input  logic signed [i2da_pkg::VALUE_BITS-1:0] value,
  output logic                                 character_valid,
  input  logic                                 character_ready,
  output logic [7:0]                           character,
  output logic                                 last
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                        state;
  logic                              neg;
  logic [i2da_pkg::BCD_BITS-1:0]     bcd;
  logic [i2da_pkg::VALUE_BITS-1:0]   mag;
  logic [i2da_pkg::CNT_BITS-1:0]     cnt;
  logic [i2da_pkg::DIG_BITS-1:0]     dig_left;
  logic [i2da_pkg::BCD_BITS-1:0]     bcd_next;
  logic [i2da_pkg::VALUE_BITS-1:0]   mag_next;
  logic [3:0]                        top_nib;
  logic                              slot_free;
  logic                              emit_now;

  i2da_dabble u_dabble (
    .bcd      (bcd),
    .mag      (mag),
    .bcd_next (bcd_next),
    .mag_next (mag_next)
  );

  assign value_ready = (state == ST_IDLE);
  assign top_nib     = bcd[i2da_pkg::BCD_BITS-1 -: 4];
  assign slot_free   = !character_valid || character_ready;
  assign emit_now    = slot_free && (state == ST_SIGN || state == ST_EMIT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      character_valid <= 1'b0;
    end else begin
      if (character_valid && character_ready && !emit_now) begin
        character_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (value_valid) begin
            neg <= value[i2da_pkg::VALUE_BITS-1];
            if (value[i2da_pkg::VALUE_BITS-1]) begin
              mag <= ~$unsigned(value) + 1'b1;
            end else begin
              mag <= $unsigned(value);
            end
            bcd   <= '0;
            cnt   <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          bcd <= bcd_next;
          mag <= mag_next;
          cnt <= cnt + 1'b1;
          if (cnt == i2da_pkg::CNT_BITS'(i2da_pkg::VALUE_BITS - 1)) begin
            dig_left <= i2da_pkg::DIG_BITS'(i2da_pkg::DIGITS);
            state    <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Drop leading zeros, keeping at least one digit.
          if (top_nib == 4'd0 && dig_left > i2da_pkg::DIG_BITS'(1)) begin
            bcd      <= {bcd[i2da_pkg::BCD_BITS-5:0], 4'd0};
            dig_left <= dig_left - 1'b1;
          end else if (neg) begin
            state <= ST_SIGN;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SIGN: begin
          if (slot_free) begin
            character_valid <= 1'b1;
            character       <= i2da_pkg::ASCII_MINUS;
            last            <= 1'b0;
            state           <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            character_valid <= 1'b1;
            character       <= i2da_pkg::ASCII_ZERO + {4'd0, top_nib};
            last            <= (dig_left == i2da_pkg::DIG_BITS'(1));
            bcd             <= {bcd[i2da_pkg::BCD_BITS-5:0], 4'd0};
            dig_left        <= dig_left - 1'b1;
            if (dig_left == i2da_pkg::DIG_BITS'(1)) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/i2da_checker.sv */
// Port-level checker for the decimal text converter, bound to the top level.
`timescale 1ns / 1ps
`include "int_to_decimal_ascii_macros.svh"

module i2da_checker (
  input logic       clk,
  input logic       rst,
  input logic       value_valid,
  input logic       value_ready,
  input logic       character_valid,
  input logic       character_ready,
  input logic [7:0] character,
  input logic       last
);

  `I2DA_ASSERT_NEXT(a_out_hold, clk, rst, character_valid && !character_ready, character_valid && $stable(character) && $stable(last))
  `I2DA_ASSERT_NEXT(a_busy_after_accept, clk, rst, value_valid && value_ready, !value_ready)
  `I2DA_ASSERT_SAME(a_idle_only_after_last, clk, rst, value_ready && character_valid, last)
  `I2DA_ASSERT_SAME(a_char_code, clk, rst, character_valid, (character == i2da_pkg::ASCII_MINUS && !last) || (character >= i2da_pkg::ASCII_ZERO && character <= i2da_pkg::ASCII_NINE))

endmodule

bind int_to_decimal_ascii i2da_checker u_i2da_checker (
  .clk             (clk),
  .rst             (rst),
  .value_valid     (value_valid),
  .value_ready     (value_ready),
  .character_valid (character_valid),
  .character_ready (character_ready),
  .character       (character),
  .last            (last)
);

/* dv/tb.sv */
// Testbench for the signed integer to decimal ASCII converter.
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic                                   clk = 1'b0;
  logic                                   rst = 1'b1;
  logic                                   value_valid = 1'b0;
  logic                                   value_ready;
  logic signed [i2da_pkg::VALUE_BITS-1:0] value = '0;
  logic                                   character_valid;
  logic                                   character_ready = 1'b0;
  logic [7:0]                             character;
  logic                                   last;

  text_char_t text_q[$];
  int         mismatches = 0;
  int         chars_seen = 0;
  int         values_sent = 0;
  logic       idle_en = 1'b1;
  int         stall_left = 0;

  int_to_decimal_ascii u_top (
    .clk             (clk),
    .rst             (rst),
    .value_valid     (value_valid),
    .value_ready     (value_ready),
    .value           (value),
    .character_valid (character_valid),
    .character_ready (character_ready),
    .character       (character),
    .last            (last)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("Timeout: %0d characters still expected", text_q.size());
    $display("Test completed with failures");
    $finish;
  end

  // Append the decimal text of one value to the expected characters.
  function automatic void push_decimal_text(input logic signed [i2da_pkg::VALUE_BITS-1:0] v);
    logic [i2da_pkg::VALUE_BITS-1:0] mag;
    logic [3:0]                      digs[$];
    text_char_t                      c;
    mag = v[i2da_pkg::VALUE_BITS-1] ? (~v + 1'b1) : v;
    do begin
      digs.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[i2da_pkg::VALUE_BITS-1]) begin
      c.code = i2da_pkg::ASCII_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    foreach (digs[i]) begin
      c.code = i2da_pkg::ASCII_ZERO + 8'(digs[i]);
      c.last = (i == digs.size() - 1);
      text_q.push_back(c);
    end
  endfunction

  // Mix full-range values, values with a chosen digit count, and near-extremes.
  function automatic logic signed [i2da_pkg::VALUE_BITS-1:0] pick_value();
    longint unsigned lim;
    longint unsigned m;
    int              k;
    logic [i2da_pkg::VALUE_BITS-1:0] v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1, 2: begin
        k = $urandom_range(1, 10);
        lim = 1;
        repeat (k) lim = lim * 10;
        m = {$urandom, $urandom} % lim;
        v = m[i2da_pkg::VALUE_BITS-1:0];
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        v = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        v = v + $urandom_range(0, 20) - 10;
      end
    endcase
    return v;
  endfunction

  task automatic send_value(input logic signed [i2da_pkg::VALUE_BITS-1:0] v);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      value_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    value       <= v;
    value_valid <= 1'b1;
    do @(posedge clk); while (!value_ready);
    push_decimal_text(v);
    values_sent++;
  endtask

  // Hold off the sender until every expected character has come out.
  task automatic drain_text();
    value_valid <= 1'b0;
    wait (text_q.size() == 0);
    @(posedge clk);
  endtask

  task automatic test_extremes();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(32'sh7FFF_FFFF);
    send_value(32'sh8000_0000);
    send_value(32'sh7FFF_FFFE);
    send_value(32'sh8000_0001);
  endtask

  // Every digit count from one to ten: each power of ten from 10 to 10^9, and the negated value just below it.
  task automatic test_digit_counts();
    int p;
    p = 1;
    repeat (9) begin
      p = p * 10;
      send_value(p);
      send_value(-(p - 1));
    end
  endtask

  task automatic test_random_values();
    repeat (320) send_value(pick_value());
  endtask

  task automatic test_backlog_drain();
    repeat (10) send_value(pick_value());
    drain_text();
    repeat (5) send_value(pick_value());
  endtask

  task automatic test_steady_stream();
    idle_en <= 1'b0;
    repeat (110) send_value(pick_value());
  endtask

  // Output side: random stall bursts, started only while idle_en is set.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left      <= stall_left - 1;
      character_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left      <= $urandom_range(0, 2);
      character_ready <= 1'b0;
    end else begin
      character_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    text_char_t exp_c;
    if (!rst && character_valid && character_ready) begin
      chars_seen++;
      if (text_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected character %0d last %0b", $realtime, character, last);
      end else begin
        exp_c = text_q.pop_front();
        if (character !== exp_c.code || last !== exp_c.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR %0t: character %0d last %0b, expected %0d last %0b",
                     $realtime, character, last, exp_c.code, exp_c.last);
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_digit_counts();
    test_random_values();
    test_backlog_drain();
    test_steady_stream();
    value_valid <= 1'b0;
    wait (text_q.size() == 0);
    repeat (80) @(posedge clk);
    if (text_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d characters never came out", text_q.size());
    end
    $display("Converted %0d values into %0d characters, %0d mismatches",
             values_sent, chars_seen, mismatches);
    $display("Covered zero, both extremes, every digit count and random signed values");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* int_to_decimal_ascii.f */
+incdir+hw/rtl
hw/rtl/i2da_pkg.sv
hw/rtl/i2da_dabble.sv
hw/rtl/int_to_decimal_ascii.sv
hw/rtl/i2da_checker.sv
dv/tb.sv
